// File: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared definitions of the Taylor exponential series block
// Field widths, fixed-point constants, microcode formats and the control
// program of the sequencer.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int X_W             = 21;
    localparam int SUM_W           = 64;
    localparam int NT_W            = 7;
    localparam int X_FRAC          = 16;
    localparam int NUM_TERMS_RESET = 10;

    localparam logic [SUM_W-1:0] MAG_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int HALF_W   = SUM_W / 2;
    localparam int PART_W   = HALF_W + X_W;
    localparam int PROD_W   = SUM_W + X_W;
    localparam int RADIX_W  = 4;
    localparam int DIVD_W   = 72;
    localparam int DIV_STEPS = DIVD_W / RADIX_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);

    localparam int PC_W = 4;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t A_IDLE     = 4'd0;
    localparam pc_t A_FIRST    = 4'd1;
    localparam pc_t A_ACC      = 4'd2;
    localparam pc_t A_TEST     = 4'd3;
    localparam pc_t A_MUL_LO   = 4'd4;
    localparam pc_t A_MUL_HI   = 4'd5;
    localparam pc_t A_DIV_INIT = 4'd6;
    localparam pc_t A_DIV      = 4'd7;
    localparam pc_t A_CLIP     = 4'd8;
    localparam pc_t A_OUT      = 4'd9;
    localparam pc_t A_RETURN   = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ACC,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CLIP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_LAST_TERM,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic last_term;
        logic div_busy;
        logic out_busy;
    } stat_t;

    function automatic ctrl_t ucode_word(input pc_t addr);
        ctrl_t w;
        unique case (addr)
            A_IDLE:     w = '{op: OP_LOAD,     cond: C_NO_INPUT,  target: A_IDLE};
            A_FIRST:    w = '{op: OP_NOP,      cond: C_LAST_TERM, target: A_OUT};
            A_ACC:      w = '{op: OP_ACC,      cond: C_NEXT,      target: A_IDLE};
            A_TEST:     w = '{op: OP_NOP,      cond: C_LAST_TERM, target: A_OUT};
            A_MUL_LO:   w = '{op: OP_MUL_LO,   cond: C_NEXT,      target: A_IDLE};
            A_MUL_HI:   w = '{op: OP_MUL_HI,   cond: C_NEXT,      target: A_IDLE};
            A_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,      target: A_IDLE};
            A_DIV:      w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,  target: A_DIV};
            A_CLIP:     w = '{op: OP_CLIP,     cond: C_ALWAYS,    target: A_ACC};
            A_OUT:      w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  target: A_OUT};
            A_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,    target: A_IDLE};
            default:    w = '{op: OP_NOP,      cond: C_ALWAYS,    target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/taylor_exp_series_top.sv
// ----------------------------------------------------------------------------
// taylor_exp_series_top: truncated Maclaurin series of exp(x)
// Sums num_terms terms of x^i/i! for a Q5.16 argument into a saturating
// signed sum with FRAC_BITS fraction bits, under microcode control.
// ----------------------------------------------------------------------------
// One request is worked on at a time. After it is accepted, a check step
// tests whether any term is wanted. The first term then passes through the
// accumulate and test steps, and each later term through those two steps,
// two passes of the shared 32 by 21 bit multiplier, a divider set-up step,
// 18 radix-16 steps of the divider by the term index and a clipping step
// (num_terms limited to MAX_TERMS). The next request is taken by way of the
// return step once the result has been placed in the output register, which
// is loaded only when it is free and holds the result until it is taken.
module taylor_exp_series_top
    import tes_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [X_W-1:0]   s_x_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_exp_sum,
    output logic                    m_saturated,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [NT_W-1:0]         cfg_num_terms
);

    ctrl_t ctrl;
    stat_t stat;

    tes_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    tes_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl_i        (ctrl),
        .stat_o        (stat),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_value     (s_x_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_exp_sum     (m_exp_sum),
        .m_saturated   (m_saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_num_terms (cfg_num_terms)
    );

endmodule

// File: rtl/tes_sequencer.sv
// ----------------------------------------------------------------------------
// tes_sequencer: microcode step counter
// Holds the program counter, fetches the control word from the program
// table and resolves conditional jumps from the datapath status.
// ----------------------------------------------------------------------------
module tes_sequencer
    import tes_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat_i,
    output ctrl_t ctrl_o
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign ctrl_o = ucode_word(pc_reg);

    always_comb begin
        unique case (ctrl_o.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !stat_i.in_valid;
            C_LAST_TERM: take = stat_i.last_term;
            C_DIV_BUSY:  take = stat_i.div_busy;
            C_OUT_BUSY:  take = stat_i.out_busy;
            default:     take = 1'b1;
        endcase
        pc_next = take ? ctrl_o.target : pc_reg + pc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= A_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: rtl/tes_datapath.sv
// ----------------------------------------------------------------------------
// tes_datapath: term and sum datapath
// Shared 32 by 21 bit multiplier, radix-16 divider by the term index,
// saturating accumulator, configuration register and output register.
// ----------------------------------------------------------------------------
module tes_datapath
    import tes_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ctrl_t                   ctrl_i,
    output stat_t                   stat_o,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [X_W-1:0]   s_x_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_exp_sum,
    output logic                    m_saturated,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [NT_W-1:0]         cfg_num_terms
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [NT_W-1:0]   num_terms_reg;
    logic [X_W-1:0]    ax_reg;
    logic              xneg_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  mag_reg;
    logic              tneg_reg;
    logic              sat_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PART_W-1:0] lo_reg;
    logic [PART_W-1:0] hi_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic              out_sat_reg;

    logic [CNT_W-1:0]  n_next;
    logic [X_W-1:0]    ax_next;
    logic [HALF_W-1:0] mul_a;
    logic [PART_W-1:0] mul_p;
    logic [PROD_W-1:0] prod_full;
    logic [SUM_W-1:0]  term_val;
    logic [SUM_W:0]    sum_wide;
    logic              sum_ovf;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  rem_next;
    logic [RADIX_W-1:0] qdig;
    logic [DIVD_W-1:0] dvd_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (ctrl_i.op == OP_LOAD);
    assign cfg_ready = 1'b1;

    assign stat_o.in_valid  = s_valid;
    assign stat_o.last_term = (cnt_reg == n_reg);
    assign stat_o.div_busy  = (dcnt_reg != DCNT_W'(DIV_STEPS - 1));
    assign stat_o.out_busy  = !out_free;

    assign m_valid     = out_valid_reg;
    assign m_exp_sum   = out_sum_reg;
    assign m_saturated = out_sat_reg;

    always_comb begin
        n_next = (num_terms_reg > NT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                    : CNT_W'(num_terms_reg);
        ax_next = s_x_value[X_W-1] ? X_W'(-s_x_value) : X_W'(s_x_value);
    end

    // The one multiplier takes the low half of the term first, then the high half.
    assign mul_a     = (ctrl_i.op == OP_MUL_HI) ? mag_reg[SUM_W-1:HALF_W] : mag_reg[HALF_W-1:0];
    assign mul_p     = PART_W'(mul_a * ax_reg);
    assign prod_full = {hi_reg, {HALF_W{1'b0}}} + PROD_W'(lo_reg);

    always_comb begin
        term_val = tneg_reg ? -mag_reg : mag_reg;
        sum_wide = {sum_reg[SUM_W-1], sum_reg} + {term_val[SUM_W-1], term_val};
        sum_ovf  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
        if (sum_ovf) begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // Four restoring division steps per cycle; the quotient shifts in at the bottom.
    always_comb begin
        rem_next = rem_reg;
        trial    = '0;
        qdig     = '0;
        for (int k = 0; k < RADIX_W; k++) begin
            trial = {rem_next, dvd_reg[DIVD_W-1-k]};
            if (trial >= {1'b0, cnt_reg}) begin
                trial = trial - {1'b0, cnt_reg};
                qdig[RADIX_W-1-k] = 1'b1;
            end
            rem_next = trial[CNT_W-1:0];
        end
        dvd_next = {dvd_reg[DIVD_W-RADIX_W-1:0], qdig};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_terms_reg <= NT_W'(NUM_TERMS_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                num_terms_reg <= cfg_num_terms;
            end
            if (ctrl_i.op == OP_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl_i.op)
            OP_LOAD: begin
                if (s_valid) begin
                    ax_reg   <= ax_next;
                    xneg_reg <= s_x_value[X_W-1];
                    n_reg    <= n_next;
                    cnt_reg  <= '0;
                    mag_reg  <= SUM_W'(1) << FRAC_BITS;
                    tneg_reg <= 1'b0;
                    sat_reg  <= 1'b0;
                    sum_reg  <= '0;
                end
            end
            OP_ACC: begin
                sum_reg <= sum_next;
                sat_reg <= sat_reg | sum_ovf;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_MUL_LO: begin
                lo_reg <= mul_p;
            end
            OP_MUL_HI: begin
                hi_reg <= mul_p;
            end
            OP_DIV_INIT: begin
                dvd_reg  <= DIVD_W'(prod_full >> X_FRAC);
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                dvd_reg  <= dvd_next;
                rem_reg  <= rem_next;
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            OP_CLIP: begin
                if (dvd_reg[DIVD_W-1:SUM_W-1] != '0) begin
                    mag_reg <= MAG_LIMIT;
                    sat_reg <= 1'b1;
                end else begin
                    mag_reg <= dvd_reg[SUM_W-1:0];
                end
                tneg_reg <= tneg_reg ^ xneg_reg;
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_sum_reg <= sum_reg;
                    out_sat_reg <= sat_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
